### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed: invariant violated");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### sv/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and constants of the stream byte reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

  localparam int IDX_W   = 32;  // stream index
  localparam int BYTE_W  = 8;
  localparam int SPACE_W = 6;   // downstream free space
  localparam int HELD_W  = 6;   // held byte count
  localparam int RUN_MAX = 32;  // most words one item may deliver

  typedef enum logic {
    KIND_BYTE,  // carries a payload byte
    KIND_MARK   // empty item, possibly with an end mark
  } item_kind_e;

  typedef enum logic {
    ST_EVAL,
    ST_DRAIN
  } state_e;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [BYTE_W-1:0]  data;
    item_kind_e         kind;
    logic               set_end;
    logic [IDX_W-1:0]   end_val;
    logic [SPACE_W-1:0] space;    // already clamped
  } item_t;

endpackage

`default_nettype wire

### sv/stream_byte_reassembler.sv
// Path: an accepted word waits in the front-end queue, is evaluated by the back
// end and is registered in the output word register as its first result.
// Throughput: one input word per cycle while no held bytes are drained and the
// output is not stalled; each extra delivered byte is read from the window
// buffer one window read per cycle, so an item delivers 1 to 32 words.
// Reset: asynchronous, active low; clears stream state, valid marks and queue;
// the byte buffer itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// stream_byte_reassembler
// Reorders indexed stream bytes into in-order delivery with a window buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_byte_reassembler #(
  parameter int WINDOW_SIZE = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [sbr_pkg::IDX_W-1:0]          byte_index_i,
  input  wire  [sbr_pkg::BYTE_W-1:0]         data_byte_i,
  input  wire                                segment_end_i,
  input  wire                                final_segment_i,
  input  wire                                empty_segment_i,
  input  wire  [sbr_pkg::SPACE_W-1:0]        downstream_space_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [sbr_pkg::BYTE_W-1:0]         out_byte_o,
  output logic                               byte_valid_o,
  output logic                               stream_closed_o,
  output logic [sbr_pkg::HELD_W-1:0]         pending_count_o,
  output logic                               run_last_o
);

  sbr_pkg::item_t item;
  logic           item_valid, item_pop;

  sbr_front #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .byte_index_i       (byte_index_i),
    .data_byte_i        (data_byte_i),
    .segment_end_i      (segment_end_i),
    .final_segment_i    (final_segment_i),
    .empty_segment_i    (empty_segment_i),
    .downstream_space_i (downstream_space_i),
    .item_o             (item),
    .item_valid_o       (item_valid),
    .item_pop_i         (item_pop)
  );

  sbr_back #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .item_valid_i    (item_valid),
    .item_pop_o      (item_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .stream_closed_o (stream_closed_o),
    .pending_count_o (pending_count_o),
    .run_last_o      (run_last_o)
  );

endmodule

`default_nettype wire

### sv/sbr_front.sv
// ----------------------------------------------------------------------------
// sbr_front
// Input side: classifies each word (byte or mark, end position, clamped
// space) and holds it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_front #(
  parameter int WINDOW_SIZE = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [sbr_pkg::IDX_W-1:0]          byte_index_i,
  input  wire  [sbr_pkg::BYTE_W-1:0]         data_byte_i,
  input  wire                                segment_end_i,
  input  wire                                final_segment_i,
  input  wire                                empty_segment_i,
  input  wire  [sbr_pkg::SPACE_W-1:0]        downstream_space_i,
  output sbr_pkg::item_t                     item_o,
  output logic                               item_valid_o,
  input  wire                                item_pop_i
);

  localparam int SPACE_LIM = (WINDOW_SIZE < sbr_pkg::RUN_MAX) ? WINDOW_SIZE
                                                              : sbr_pkg::RUN_MAX;
  localparam logic [sbr_pkg::SPACE_W-1:0] SPACE_CAP = SPACE_LIM[sbr_pkg::SPACE_W-1:0];
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  sbr_pkg::item_t item_in;
  sbr_pkg::item_t queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic push, pop;

  always_comb begin
    item_in.idx     = byte_index_i;
    item_in.data    = data_byte_i;
    item_in.kind    = empty_segment_i ? sbr_pkg::KIND_MARK : sbr_pkg::KIND_BYTE;
    item_in.set_end = final_segment_i & (empty_segment_i | segment_end_i);
    // an empty final item marks the end at its own index
    item_in.end_val = empty_segment_i ? byte_index_i : byte_index_i + 1'b1;
    item_in.space   = (downstream_space_i > SPACE_CAP) ? SPACE_CAP : downstream_space_i;
  end

  assign in_stall_o   = (count_q == QDEPTH[QPTR_W:0]);
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i & ~in_stall_o;
  assign pop          = item_pop_i & item_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/sbr_back.sv
// ----------------------------------------------------------------------------
// sbr_back
// Execution side: owns the stream state and the window buffer, places or
// delivers each word, drains consecutive held bytes one per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sbr_back #(
  parameter int WINDOW_SIZE = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  sbr_pkg::item_t                     item_i,
  input  wire                                item_valid_i,
  output logic                               item_pop_o,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [sbr_pkg::BYTE_W-1:0]         out_byte_o,
  output logic                               byte_valid_o,
  output logic                               stream_closed_o,
  output logic [sbr_pkg::HELD_W-1:0]         pending_count_o,
  output logic                               run_last_o
);

  localparam int SLOT_W = $clog2(WINDOW_SIZE);
  localparam logic [SLOT_W:0]   WIN_VAL   = WINDOW_SIZE[SLOT_W:0];
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SIZE - 1);

  sbr_pkg::state_e state_q, state_d;

  logic [sbr_pkg::IDX_W-1:0]   ne_q, ne_d, end_q, end_d;
  logic [SLOT_W-1:0]           ne_slot_q, ne_slot_d;
  logic                        known_q, known_d, closed_q, closed_d;
  logic [WINDOW_SIZE-1:0]      valid_q, valid_d;
  logic [sbr_pkg::HELD_W-1:0]  held_q, held_d;
  logic [sbr_pkg::SPACE_W-1:0] rem_q, rem_d;

  logic [sbr_pkg::BYTE_W-1:0]  win_mem_q [WINDOW_SIZE];
  logic [sbr_pkg::BYTE_W-1:0]  rd_data_q;
  logic                        rd_en, wr_en;
  logic [SLOT_W-1:0]           rd_addr, wr_addr;

  logic                        out_free, emit, emit_bv, emit_last, do_close;
  logic [sbr_pkg::BYTE_W-1:0]  emit_byte;

  // item classification against the current state
  logic [sbr_pkg::IDX_W:0]     diff;
  logic [sbr_pkg::IDX_W-1:0]   off, ne_inc, end_w;
  logic                        known_w, ok, off_zero;
  logic [SLOT_W:0]             slot_sum;
  logic [SLOT_W-1:0]           store_slot, nslot;

  assign end_w    = item_i.set_end ? item_i.end_val : end_q;
  assign known_w  = known_q | item_i.set_end;
  assign diff     = {1'b0, item_i.idx} - {1'b0, ne_q};
  assign off      = diff[sbr_pkg::IDX_W-1:0];
  assign off_zero = (off == '0);
  assign ok       = ~diff[sbr_pkg::IDX_W]
                  & (off[sbr_pkg::IDX_W-1:sbr_pkg::SPACE_W] == '0)
                  & (off[sbr_pkg::SPACE_W-1:0] < item_i.space)
                  & ~(known_w & (item_i.idx >= end_w));
  // off stays below the window size whenever ok, so one subtract wraps it
  assign slot_sum   = {1'b0, ne_slot_q} + {1'b0, off[SLOT_W-1:0]};
  assign store_slot = (slot_sum >= WIN_VAL) ? SLOT_W'(slot_sum - WIN_VAL)
                                            : slot_sum[SLOT_W-1:0];
  // the slot restarts at zero when the index wraps
  assign nslot      = ((ne_slot_q == LAST_SLOT) || (&ne_q)) ? '0 : ne_slot_q + 1'b1;
  assign ne_inc     = ne_q + 1'b1;
  assign out_free   = ~out_valid_o | ~out_stall_i;

  always_comb begin
    state_d    = state_q;
    ne_d       = ne_q;
    ne_slot_d  = ne_slot_q;
    end_d      = end_q;
    known_d    = known_q;
    closed_d   = closed_q;
    valid_d    = valid_q;
    held_d     = held_q;
    rem_d      = rem_q;
    item_pop_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = nslot;
    wr_en      = 1'b0;
    wr_addr    = store_slot;
    emit       = 1'b0;
    emit_bv    = 1'b0;
    emit_byte  = '0;
    emit_last  = 1'b1;
    do_close   = 1'b0;

    unique case (state_q)
      sbr_pkg::ST_EVAL: begin
        if (item_valid_i && out_free) begin
          emit       = 1'b1;
          item_pop_o = 1'b1;
          if (!closed_q) begin
            end_d   = end_w;
            known_d = known_w;
            if (item_i.kind == sbr_pkg::KIND_BYTE && ok && off_zero) begin
              if (valid_q[ne_slot_q]) begin
                valid_d[ne_slot_q] = 1'b0;
                held_d             = held_q - 1'b1;
              end
              ne_d      = ne_inc;
              ne_slot_d = nslot;
              rem_d     = item_i.space - 1'b1;
              emit_bv   = 1'b1;
              emit_byte = item_i.data;
              if (known_w && (ne_inc >= end_w)) begin
                do_close = 1'b1;
              end else if ((rem_d != '0) && valid_q[nslot]) begin
                rd_en     = 1'b1;
                emit_last = 1'b0;
                state_d   = sbr_pkg::ST_DRAIN;
              end
            end else begin
              if (item_i.kind == sbr_pkg::KIND_BYTE && ok) begin
                wr_en = 1'b1;
                if (!valid_q[store_slot]) begin
                  valid_d[store_slot] = 1'b1;
                  held_d              = held_q + 1'b1;
                end
              end
              do_close = known_w && (ne_q >= end_w);
            end
          end
        end
      end
      sbr_pkg::ST_DRAIN: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_bv            = 1'b1;
          emit_byte          = rd_data_q;
          valid_d[ne_slot_q] = 1'b0;
          held_d             = held_q - 1'b1;
          ne_d               = ne_inc;
          ne_slot_d          = nslot;
          rem_d              = rem_q - 1'b1;
          state_d            = sbr_pkg::ST_EVAL;
          if (known_q && (ne_inc >= end_q)) begin
            do_close = 1'b1;
          end else if ((rem_d != '0) && valid_q[nslot]) begin
            rd_en     = 1'b1;
            emit_last = 1'b0;
            state_d   = sbr_pkg::ST_DRAIN;
          end
        end
      end
      default: state_d = sbr_pkg::ST_EVAL;
    endcase

    if (do_close) begin
      closed_d = 1'b1;
      valid_d  = '0;
      held_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) win_mem_q[wr_addr] <= item_i.data;
    if (rd_en) rd_data_q <= win_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sbr_pkg::ST_EVAL;
      ne_q      <= '0;
      ne_slot_q <= '0;
      end_q     <= '0;
      known_q   <= 1'b0;
      closed_q  <= 1'b0;
      valid_q   <= '0;
      held_q    <= '0;
      rem_q     <= '0;
    end else begin
      state_q   <= state_d;
      ne_q      <= ne_d;
      ne_slot_q <= ne_slot_d;
      end_q     <= end_d;
      known_q   <= known_d;
      closed_q  <= closed_d;
      valid_q   <= valid_d;
      held_q    <= held_d;
      rem_q     <= rem_d;
    end
  end

  // output word register; status reflects state after this word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_o      <= emit_byte;
      byte_valid_o    <= emit_bv;
      stream_closed_o <= closed_d;
      pending_count_o <= held_d;
      run_last_o      <= emit_last;
    end
  end

  `ASSERT_ALWAYS(a_held_matches_marks, clk_i, rst_ni, held_q == $countones(valid_q))
  `ASSERT_IMPLIES(a_closed_no_marks, clk_i, rst_ni, closed_q, valid_q == '0)
  `ASSERT_IMPLIES(a_drain_open, clk_i, rst_ni, state_q == sbr_pkg::ST_DRAIN, !closed_q)
  `ASSERT_IMPLIES(a_drain_slot_held, clk_i, rst_ni, state_q == sbr_pkg::ST_DRAIN, valid_q[ne_slot_q])

endmodule

`default_nettype wire
